### design/card_number_luhn_brand_check_top_defines.svh
// Assertion macros shared by the card check design.
`ifndef CARD_NUMBER_LUHN_BRAND_CHECK_TOP_DEFINES_SVH
`define CARD_NUMBER_LUHN_BRAND_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CNLBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CNLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cnlbc_pkg.sv
`timescale 1ns / 1ps

package cnlbc_pkg;

    // Width of the binary card number.
    localparam int CARD_W = 63;
    // Number of decimal digit cells; 2^63 stays below 10^19.
    localparam int NUM_DIGITS = 19;
    // Width of one BCD digit.
    localparam int DIGIT_W = 4;
    // Width of the digit index and of the digit count.
    localparam int IDX_W = 5;

    // Brand codes on the result.
    localparam logic [1:0] BRAND_NONE  = 2'd0;
    localparam logic [1:0] BRAND_ONE   = 2'd1;
    localparam logic [1:0] BRAND_TWO   = 2'd2;
    localparam logic [1:0] BRAND_THREE = 2'd3;

    // Operation of every digit cell in one cycle.
    typedef struct packed {
        logic clear;
        logic conv;
        logic drain;
    } t_cell_ctl;

endpackage

### design/cnlbc_digit_cell.sv
`timescale 1ns / 1ps

module cnlbc_digit_cell (
    input  logic                               i_clk,
    input  cnlbc_pkg::t_cell_ctl               i_ctl,
    input  logic                               i_bit,
    input  logic [cnlbc_pkg::DIGIT_W-1:0]      i_digit,
    output logic                               o_carry,
    output logic [cnlbc_pkg::DIGIT_W-1:0]      o_digit
);

    logic [cnlbc_pkg::DIGIT_W-1:0] r_digit;
    logic [cnlbc_pkg::DIGIT_W-1:0] n_digit;
    logic [cnlbc_pkg::DIGIT_W-1:0] w_adj;

    // Add three when the digit is five or more, so the shift carries correctly.
    always_comb begin
        w_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    end

    assign o_carry = w_adj[cnlbc_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    // Clear, shift one binary bit in, or take the digit of the next higher cell.
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.conv) begin
            n_digit = {w_adj[cnlbc_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctl.drain) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

### design/cnlbc_luhn_scan.sv
`timescale 1ns / 1ps

module cnlbc_luhn_scan (
    input  logic                            i_clk,
    input  logic                            i_clear,
    input  logic                            i_valid,
    input  logic [cnlbc_pkg::DIGIT_W-1:0]   i_digit,
    input  logic [cnlbc_pkg::IDX_W-1:0]     i_index,
    output logic [1:0]                      o_brand_code,
    output logic                            o_checksum_ok,
    output logic [cnlbc_pkg::IDX_W-1:0]     o_digit_count
);

    localparam logic [cnlbc_pkg::IDX_W-1:0] LEN_13 = 5'd13;
    localparam logic [cnlbc_pkg::IDX_W-1:0] LEN_15 = 5'd15;
    localparam logic [cnlbc_pkg::IDX_W-1:0] LEN_16 = 5'd16;

    logic [cnlbc_pkg::DIGIT_W-1:0] r_sum;
    logic [cnlbc_pkg::IDX_W-1:0]   r_count;
    logic [cnlbc_pkg::DIGIT_W-1:0] r_prev;
    logic [cnlbc_pkg::DIGIT_W-1:0] r_hi;
    logic [cnlbc_pkg::DIGIT_W-1:0] r_lo;
    logic [cnlbc_pkg::DIGIT_W-1:0] w_term;
    logic [cnlbc_pkg::DIGIT_W:0]   w_add;
    logic [cnlbc_pkg::DIGIT_W-1:0] n_sum;

    // Digits at odd index (even position from the right) are doubled and folded.
    always_comb begin
        if (i_index[0]) begin
            w_term = (i_digit >= 4'd5) ? ((i_digit << 1) - 4'd9) : (i_digit << 1);
        end else begin
            w_term = i_digit;
        end
        w_add = {1'b0, r_sum} + {1'b0, w_term};
        n_sum = (w_add >= 5'd10) ? 4'(w_add - 5'd10) : w_add[cnlbc_pkg::DIGIT_W-1:0];
    end

    // Running sum modulo ten, length and the two leading digits.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_sum   <= '0;
            r_count <= '0;
            r_prev  <= '0;
            r_hi    <= '0;
            r_lo    <= '0;
        end else if (i_valid) begin
            r_sum  <= n_sum;
            r_prev <= i_digit;
            if (i_digit != '0) begin
                r_count <= i_index + 5'd1;
                r_hi    <= i_digit;
                r_lo    <= r_prev;
            end
        end
    end

    // Brand rules in priority order; every brand needs a passing checksum.
    always_comb begin
        o_checksum_ok = (r_sum == '0);
        o_digit_count = r_count;
        o_brand_code  = cnlbc_pkg::BRAND_NONE;
        if (o_checksum_ok) begin
            if (r_hi == 4'd3 && (r_lo == 4'd4 || r_lo == 4'd7) && r_count == LEN_15) begin
                o_brand_code = cnlbc_pkg::BRAND_ONE;
            end else if (r_hi == 4'd5 && r_lo >= 4'd1 && r_lo <= 4'd5
                         && r_count == LEN_16) begin
                o_brand_code = cnlbc_pkg::BRAND_TWO;
            end else if (r_hi == 4'd4 && (r_count == LEN_13 || r_count == LEN_16)) begin
                o_brand_code = cnlbc_pkg::BRAND_THREE;
            end
        end
    end

endmodule

### design/card_number_luhn_brand_check_top.sv
`timescale 1ns / 1ps
// Card number check: give a 63-bit binary card number with start while busy is low.
// The number is converted to 19 BCD digits in a row of digit cells, one binary bit per
// cycle, then the digits are shifted out of the row one per cycle into the Luhn and
// prefix scanner. The result appears on o_valid for exactly one cycle, and the next item
// can be taken in that same cycle, so work on one item ends before the next is accepted.
// The receiver cannot stall: o_valid is a strobe and the result fields keep their value
// until the next result.

`include "card_number_luhn_brand_check_top_defines.svh"

module card_number_luhn_brand_check_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cnlbc_pkg::CARD_W-1:0]  i_card_number,
    output logic                          o_valid,
    output logic [1:0]                    o_brand_code,
    output logic                          o_checksum_ok,
    output logic [cnlbc_pkg::IDX_W-1:0]   o_digit_count
);

    localparam int CNT_W = $clog2(cnlbc_pkg::CARD_W);
    localparam logic [CNT_W-1:0] CONV_LAST  = CNT_W'(cnlbc_pkg::CARD_W - 1);
    localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(cnlbc_pkg::NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                            r_state;
    logic [CNT_W-1:0]                  r_cnt;
    logic [cnlbc_pkg::CARD_W-1:0]      r_bits;
    logic                              w_accept;
    cnlbc_pkg::t_cell_ctl              w_ctl;
    logic [cnlbc_pkg::NUM_DIGITS:0]    w_carry;
    logic [cnlbc_pkg::DIGIT_W-1:0]     w_digit [cnlbc_pkg::NUM_DIGITS+1];
    logic [1:0]                        w_brand;
    logic                              w_ok;
    logic [cnlbc_pkg::IDX_W-1:0]       w_count;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Cell operation follows the phase of the sequencer.
    always_comb begin
        w_ctl.clear = w_accept;
        w_ctl.conv  = (r_state == S_CONV);
        w_ctl.drain = (r_state == S_DRAIN);
    end

    // The binary number enters the row most significant bit first.
    assign w_carry[0] = r_bits[cnlbc_pkg::CARD_W-1];
    assign w_digit[cnlbc_pkg::NUM_DIGITS] = '0;

    // Row of BCD digit cells, least significant digit in cell zero.
    for (genvar g = 0; g < cnlbc_pkg::NUM_DIGITS; g++) begin : g_cell
        cnlbc_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_carry[g]),
            .i_digit (w_digit[g+1]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g])
        );
    end

    // Scanner takes the digits as they leave cell zero, lowest digit first.
    cnlbc_luhn_scan u_scan (
        .i_clk         (i_clk),
        .i_clear       (w_accept),
        .i_valid       (w_ctl.drain),
        .i_digit       (w_digit[0]),
        .i_index       (r_cnt[cnlbc_pkg::IDX_W-1:0]),
        .o_brand_code  (w_brand),
        .o_checksum_ok (w_ok),
        .o_digit_count (w_count)
    );

    // Sequencer: conversion, drain, then one result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                    end
                end
                S_CONV: begin
                    if (r_cnt == CONV_LAST) begin
                        r_state <= S_DRAIN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_cnt == DRAIN_LAST) begin
                        r_state <= S_DONE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Input shift register and result fields carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bits <= i_card_number;
        end else if (r_state == S_CONV) begin
            r_bits <= {r_bits[cnlbc_pkg::CARD_W-2:0], 1'b0};
        end
        if (r_state == S_DONE) begin
            o_brand_code  <= w_brand;
            o_checksum_ok <= w_ok;
            o_digit_count <= w_count;
        end
    end

    `CNLBC_ASSERT_NEXT(a_accept_busy, w_accept, busy, "Accepted item did not start work.")
    `CNLBC_ASSERT_NOW(a_no_overflow, r_state == S_CONV, !w_carry[cnlbc_pkg::NUM_DIGITS],
        "Conversion overflowed the digit row.")
    `CNLBC_ASSERT_NOW(a_brand_needs_ok, o_valid && o_brand_code != cnlbc_pkg::BRAND_NONE,
        o_checksum_ok, "Brand reported without a passing checksum.")
    `CNLBC_ASSERT_NOW(a_count_range, o_valid,
        o_digit_count <= 5'(cnlbc_pkg::NUM_DIGITS), "Digit count out of range.")
    `CNLBC_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "Result strobe lasted two cycles.")

endmodule
